// ===== rtl/core/pdc_pkg.sv =====
// Shared types, constants and helper functions for the pixel display correction core.
// No dependencies; every other file in rtl/core but pdc_ram imports this package.
`timescale 1ns / 1ps

package pdc_pkg;

   // Geometry of one pixel and of the correction table
   localparam int NUM_CHANNELS = 4;
   localparam int COLOR_LANES  = 3;
   localparam int LANE_W       = $clog2(COLOR_LANES);
   localparam int PIX_W        = 8;
   localparam int TABLE_DEPTH  = 256;
   localparam int TABLE_AW     = $clog2(TABLE_DEPTH);

   // Stream and register port widths
   localparam int REQ_DATA_W = NUM_CHANNELS * PIX_W + 2 * PIX_W;
   localparam int RSP_DATA_W = NUM_CHANNELS * PIX_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 3;
   localparam int COUNT_W    = 3;

   localparam logic [COUNT_W-1:0] CHANNEL_COUNT_RESET = COUNT_W'(NUM_CHANNELS);

   // Rec.709 luma in Q16: weights sum to 65536, rounding bias is one half
   localparam int WEIGHT_W = 16;
   localparam int PROD_W   = WEIGHT_W + PIX_W;
   localparam logic [WEIGHT_W-1:0] LUMA_WEIGHT [COLOR_LANES] = '{
      16'd13933, 16'd46871, 16'd4732
   };
   localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'(32768);

   typedef logic [PIX_W-1:0] pix_type;
   typedef logic [NUM_CHANNELS-1:0][PIX_W-1:0] chan_vec_type;
   typedef logic [COLOR_LANES-1:0][PIX_W-1:0] lane_vec_type;

   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_PIXEL = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_RGBA   = 2'd0,
      MODE_RGB    = 2'd1,
      MODE_SINGLE = 2'd2,
      MODE_LUMA   = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRGB_DECODE    = 2'd0,
      CSR_DISPLAY_MODE   = 2'd1,
      CSR_CHOSEN_CHANNEL = 2'd2,
      CSR_CHANNEL_COUNT  = 2'd3
   } csr_type;

   // Settings as the datapath sees them, after clamping and mode fallback
   typedef struct packed {
      logic                srgb;
      mode_type            mode;
      logic [1:0]          sel;
      logic [COUNT_W-1:0]  total;
      logic [1:0]          colour;
   } ctl_type;

   // sRGB-to-linear, 8 bit in and out
   localparam pix_type SRGB_ROM [TABLE_DEPTH] = '{
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1,
      8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
      8'd1, 8'd1, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2,
      8'd2, 8'd2, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3,
      8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd5, 8'd5, 8'd5,
      8'd5, 8'd6, 8'd6, 8'd6, 8'd6, 8'd7, 8'd7, 8'd7,
      8'd8, 8'd8, 8'd8, 8'd8, 8'd9, 8'd9, 8'd9, 8'd10,
      8'd10, 8'd10, 8'd11, 8'd11, 8'd12, 8'd12, 8'd12, 8'd13,
      8'd13, 8'd13, 8'd14, 8'd14, 8'd15, 8'd15, 8'd16, 8'd16,
      8'd17, 8'd17, 8'd17, 8'd18, 8'd18, 8'd19, 8'd19, 8'd20,
      8'd20, 8'd21, 8'd22, 8'd22, 8'd23, 8'd23, 8'd24, 8'd24,
      8'd25, 8'd25, 8'd26, 8'd27, 8'd27, 8'd28, 8'd29, 8'd29,
      8'd30, 8'd30, 8'd31, 8'd32, 8'd32, 8'd33, 8'd34, 8'd35,
      8'd35, 8'd36, 8'd37, 8'd37, 8'd38, 8'd39, 8'd40, 8'd41,
      8'd41, 8'd42, 8'd43, 8'd44, 8'd45, 8'd45, 8'd46, 8'd47,
      8'd48, 8'd49, 8'd50, 8'd51, 8'd51, 8'd52, 8'd53, 8'd54,
      8'd55, 8'd56, 8'd57, 8'd58, 8'd59, 8'd60, 8'd61, 8'd62,
      8'd63, 8'd64, 8'd65, 8'd66, 8'd67, 8'd68, 8'd69, 8'd70,
      8'd71, 8'd72, 8'd73, 8'd74, 8'd76, 8'd77, 8'd78, 8'd79,
      8'd80, 8'd81, 8'd82, 8'd84, 8'd85, 8'd86, 8'd87, 8'd88,
      8'd90, 8'd91, 8'd92, 8'd93, 8'd95, 8'd96, 8'd97, 8'd99,
      8'd100, 8'd101, 8'd103, 8'd104, 8'd105, 8'd107, 8'd108, 8'd109,
      8'd111, 8'd112, 8'd114, 8'd115, 8'd116, 8'd118, 8'd119, 8'd121,
      8'd122, 8'd124, 8'd125, 8'd127, 8'd128, 8'd130, 8'd131, 8'd133,
      8'd134, 8'd136, 8'd138, 8'd139, 8'd141, 8'd142, 8'd144, 8'd146,
      8'd147, 8'd149, 8'd151, 8'd152, 8'd154, 8'd156, 8'd157, 8'd159,
      8'd161, 8'd163, 8'd164, 8'd166, 8'd168, 8'd170, 8'd171, 8'd173,
      8'd175, 8'd177, 8'd179, 8'd181, 8'd183, 8'd184, 8'd186, 8'd188,
      8'd190, 8'd192, 8'd194, 8'd196, 8'd198, 8'd200, 8'd202, 8'd204,
      8'd206, 8'd208, 8'd210, 8'd212, 8'd214, 8'd216, 8'd218, 8'd220,
      8'd222, 8'd224, 8'd226, 8'd229, 8'd231, 8'd233, 8'd235, 8'd237,
      8'd239, 8'd242, 8'd244, 8'd246, 8'd248, 8'd250, 8'd253, 8'd255
   };

   function automatic pix_type decode_px(logic srgb, pix_type v);
      return srgb ? SRGB_ROM[v] : v;
   endfunction

   // Clamp the channel count, derive the colour channel count, apply luma fallback
   function automatic ctl_type make_ctl(logic srgb, logic [1:0] mode, logic [1:0] sel,
                                        logic [COUNT_W-1:0] count);
      ctl_type c;
      c.srgb = srgb;
      c.sel  = sel;
      if (count == '0)
         c.total = COUNT_W'(1);
      else if (count > COUNT_W'(NUM_CHANNELS))
         c.total = COUNT_W'(NUM_CHANNELS);
      else
         c.total = count;
      if (c.total > COUNT_W'(3))
         c.colour = 2'd3;
      else if (c.total == COUNT_W'(2))
         c.colour = 2'd1;
      else
         c.colour = c.total[1:0];
      c.mode = mode_type'(mode);
      if (c.colour == 2'd1 && c.mode == MODE_LUMA)
         c.mode = MODE_RGBA;
      return c;
   endfunction

endpackage

// ===== rtl/core/pdc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds one copy of the correction table per lane.
`timescale 1ns / 1ps

module pdc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en)
         mem_ff[wr_addr] <= wr_data;
   end

   // Read port, data held while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en)
         rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/pdc_lane.sv =====
// One colour lane: sRGB decode, weighted luma product and a private correction table copy.
// Depends on pdc_pkg and pdc_ram.
`timescale 1ns / 1ps

module pdc_lane (
   input  logic                          clock,
   input  logic [pdc_pkg::LANE_W-1:0]    lane_id,
   input  logic                          srgb,
   input  logic                          load1_en,
   input  pdc_pkg::pix_type              src,
   input  logic                          load2_en,
   output pdc_pkg::pix_type              dec,
   output logic [pdc_pkg::PROD_W-1:0]    prod,
   input  logic                          wr_en,
   input  logic [pdc_pkg::TABLE_AW-1:0]  wr_addr,
   input  pdc_pkg::pix_type              wr_data,
   input  logic                          rd_en,
   input  logic [pdc_pkg::TABLE_AW-1:0]  rd_addr,
   output pdc_pkg::pix_type              rd_data
);

   import pdc_pkg::*;

   pix_type           dec1_ff, dec1_in;
   pix_type           dec2_ff, dec2_in;
   logic [PROD_W-1:0] prod_ff, prod_in;

   // Stage 1: decode at accept; stage 2: Q16 weight times decoded value
   assign dec1_in = decode_px(srgb, src);
   assign dec2_in = dec1_ff;
   assign prod_in = {{PIX_W{1'b0}}, LUMA_WEIGHT[lane_id]}
                    * {{WEIGHT_W{1'b0}}, dec1_ff};

   always_ff @(posedge clock) begin
      if (load1_en)
         dec1_ff <= dec1_in;
      if (load2_en) begin
         dec2_ff <= dec2_in;
         prod_ff <= prod_in;
      end
   end

   assign dec  = dec2_ff;
   assign prod = prod_ff;

   // Every lane keeps a full copy so all three colour lookups run in the same cycle
   pdc_ram #(
      .WIDTH (PIX_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

// ===== rtl/core/pdc_merge.sv =====
// Merge stage: combines lane lookups and raw channels per display mode into the output register.
// Depends on pdc_pkg.
`timescale 1ns / 1ps

module pdc_merge (
   input  logic                               clock,
   input  logic                               reset,
   input  pdc_pkg::ctl_type                   ctl,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  pdc_pkg::chan_vec_type              raw,
   input  pdc_pkg::lane_vec_type              lut,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [pdc_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   import pdc_pkg::*;

   logic         valid_ff, valid_in;
   chan_vec_type data_ff, data_in;
   chan_vec_type lut_all;
   pix_type      single_v;
   logic         take;

   // Lane lookups widened to one slot per channel, top slot unused
   assign lut_all = {{PIX_W{1'b0}}, lut};

   // Single-channel value: corrected if colour, raw if present, else zero
   always_comb begin
      single_v = '0;
      if ({1'b0, ctl.sel} < {1'b0, ctl.colour})
         single_v = lut[0];
      else if (COUNT_W'(ctl.sel) < ctl.total)
         single_v = raw[ctl.sel];
   end

   // Per-channel result; absent channels read as zero
   always_comb begin
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         data_in[ch] = '0;
         if (COUNT_W'(ch) < ctl.total) begin
            case (ctl.mode)
               MODE_LUMA:
                  data_in[ch] = (ch < COLOR_LANES) ? lut[0] : raw[ch];
               MODE_SINGLE:
                  data_in[ch] = (COUNT_W'(ch) < COUNT_W'(ctl.colour)) ? single_v : raw[ch];
               default: begin
                  data_in[ch] = raw[ch];
                  if (ch < COLOR_LANES && COUNT_W'(ch) < COUNT_W'(ctl.colour))
                     data_in[ch] = lut_all[ch];
               end
            endcase
         end
      end
   end

   // Output register
   assign in_ready = !valid_ff || rsp_tready;
   assign take     = in_valid && in_ready;
   assign valid_in = take || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else
         valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (take)
         data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

// ===== rtl/core/pixel_display_correction_core.sv =====
// Top level of the pixel display correction core: settings, pipeline control, lanes, merge.
// Depends on pdc_pkg, pdc_lane, pdc_merge (and pdc_ram through the lanes).
//
//   Channel | Ports        | Direction | Contents
//   --------+--------------+-----------+--------------------------------------------------
//   request | req_t*       | in        | pixel or table load command
//   result  | rsp_t*       | out       | corrected pixel, one per pixel command
//   config  | csr_*        | in        | settings writes, no read-back
//
// One item accepted per clock when not stalled; pixel results pass all stages to rsp_tvalid.
// Loads write all three lane table copies in stage 2 and give no result.
// The rate follows from each colour lane owning its own table RAM read port.
// Reset is synchronous and clears control state only; the table is undefined until loaded.
// A stalled result fills the pipeline stage by stage before req_tready drops.
`timescale 1ns / 1ps

module pixel_display_correction_core (
   input  logic                             clock,
   input  logic                             reset,
   // request: [7:0] in_c0, [15:8] in_c1, [23:16] in_c2, [31:24] in_c3,
   //          [39:32] entry_index, [47:40] entry_value
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [pdc_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                             req_tuser,   // [0] cmd
   // result: [7:0] out_c0, [15:8] out_c1, [23:16] out_c2, [31:24] out_c3
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [pdc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // settings
   input  logic                             csr_we,
   input  logic [pdc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pdc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import pdc_pkg::*;

   // Settings registers
   logic               srgb_ff, srgb_in;
   logic [1:0]         mode_ff, mode_in;
   logic [1:0]         sel_ff, sel_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   ctl_type            ctl;

   // Pipeline registers
   logic               v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   cmd_type            cmd1_ff, cmd2_ff;
   chan_vec_type       raw1_ff, raw2_ff, raw3_ff, req_chan;
   pix_type            idx1_ff, idx2_ff, val1_ff, val2_ff;

   // Handshake
   logic               req_fire, move1, move2, load_fire, read_fire;
   logic               ready1, ready2, ready3, merge_ready;

   // Lane connections
   lane_vec_type       dec2, lut;
   logic [PROD_W-1:0]  prod2 [COLOR_LANES];
   logic [PROD_W-1:0]  luma_acc;
   pix_type            luma, addr0, sel_dec;

   // Settings write decode
   always_comb begin
      srgb_in  = srgb_ff;
      mode_in  = mode_ff;
      sel_in   = sel_ff;
      count_in = count_ff;
      if (csr_we) begin
         unique case (csr_type'(csr_index))
            CSR_SRGB_DECODE:    srgb_in  = csr_wdata[0];
            CSR_DISPLAY_MODE:   mode_in  = csr_wdata[1:0];
            CSR_CHOSEN_CHANNEL: sel_in   = csr_wdata[1:0];
            CSR_CHANNEL_COUNT:  count_in = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         srgb_ff  <= 1'b0;
         mode_ff  <= MODE_RGBA;
         sel_ff   <= '0;
         count_ff <= CHANNEL_COUNT_RESET;
      end else begin
         srgb_ff  <= srgb_in;
         mode_ff  <= mode_in;
         sel_ff   <= sel_in;
         count_ff <= count_in;
      end
   end

   assign ctl = make_ctl(srgb_ff, mode_ff, sel_ff, count_ff);

   // Stage flow: loads leave at stage 2, pixels continue to the merge
   assign ready3    = !v3_ff || merge_ready;
   assign ready2    = !v2_ff || (cmd2_ff == CMD_LOAD) || ready3;
   assign ready1    = !v1_ff || ready2;
   assign req_tready = ready1;

   assign req_fire  = req_tvalid && ready1;
   assign move1     = v1_ff && ready2;
   assign move2     = v2_ff && ((cmd2_ff == CMD_LOAD) || ready3);
   assign load_fire = v2_ff && (cmd2_ff == CMD_LOAD);
   assign read_fire = move2 && (cmd2_ff == CMD_PIXEL);

   always_comb begin
      v1_in = req_fire || (v1_ff && !move1);
      v2_in = move1 || (v2_ff && !move2);
      v3_in = read_fire || (v3_ff && !merge_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // Request unpacking
   always_comb begin
      for (int ch = 0; ch < NUM_CHANNELS; ch++)
         req_chan[ch] = req_tdata[ch*PIX_W +: PIX_W];
   end

   // Payload pipeline
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd1_ff <= cmd_type'(req_tuser);
         raw1_ff <= req_chan;
         idx1_ff <= req_tdata[NUM_CHANNELS*PIX_W +: PIX_W];
         val1_ff <= req_tdata[(NUM_CHANNELS+1)*PIX_W +: PIX_W];
      end
      if (move1) begin
         cmd2_ff <= cmd1_ff;
         raw2_ff <= raw1_ff;
         idx2_ff <= idx1_ff;
         val2_ff <= val1_ff;
      end
      if (read_fire)
         raw3_ff <= raw2_ff;
   end

   // Colour lanes
   for (genvar k = 0; k < COLOR_LANES; k++) begin : g_lane
      pix_type lane_addr;

      if (k == 0) begin : g_first
         assign lane_addr = addr0;
      end else begin : g_other
         assign lane_addr = dec2[k];
      end

      pdc_lane u_lane (
         .clock    (clock),
         .lane_id  (LANE_W'(k)),
         .srgb     (ctl.srgb),
         .load1_en (req_fire),
         .src      (req_chan[k]),
         .load2_en (move1),
         .dec      (dec2[k]),
         .prod     (prod2[k]),
         .wr_en    (load_fire),
         .wr_addr  (idx2_ff),
         .wr_data  (val2_ff),
         .rd_en    (read_fire),
         .rd_addr  (lane_addr),
         .rd_data  (lut[k])
      );
   end

   // Luma: Q16 weighted sum with rounding; the sum stays below 2^24
   assign luma_acc = prod2[0] + prod2[1] + prod2[2] + ROUND_BIAS;
   assign luma     = luma_acc[PROD_W-1 -: PIX_W];

   // Lane 0 address: luma, the chosen channel or channel 0
   always_comb begin
      case (ctl.sel)
         2'd1:    sel_dec = dec2[1];
         2'd2:    sel_dec = dec2[2];
         default: sel_dec = dec2[0];
      endcase
   end

   always_comb begin
      case (ctl.mode)
         MODE_LUMA:   addr0 = luma;
         MODE_SINGLE: addr0 = sel_dec;
         default:     addr0 = dec2[0];
      endcase
   end

   // Merge and output register
   pdc_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .in_valid   (v3_ff),
      .in_ready   (merge_ready),
      .raw        (raw3_ff),
      .lut        (lut),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== rtl/core/pdc_checker.sv =====
// Port-level checker for the pixel display correction core, with its bind statement.
// Depends on pdc_pkg; attaches to pixel_display_correction_core.
`timescale 1ns / 1ps

module pdc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [pdc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic                             csr_we,
   input logic [pdc_pkg::CSR_IDX_W-1:0]    csr_index,
   input logic [pdc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import pdc_pkg::*;

   logic [COUNT_W-1:0] count_ff, count_in;
   ctl_type            shadow_ctl;
   logic [COUNT_W-1:0] total;

   // Shadow of the channel count as seen on the settings port
   assign count_in = (csr_we && csr_type'(csr_index) == CSR_CHANNEL_COUNT) ? csr_wdata
                                                                           : count_ff;

   always_ff @(posedge clock) begin
      if (reset)
         count_ff <= CHANNEL_COUNT_RESET;
      else
         count_ff <= count_in;
   end

   assign shadow_ctl = make_ctl(1'b0, 2'd0, 2'd0, count_ff);
   assign total      = shadow_ctl.total;

   // No result right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Channel 3 is zero when fewer than four channels are present
   a_c3_absent: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) && ($past(total) != COUNT_W'(4)) |-> rsp_tdata[31:24] == 8'd0)
      else $error("absent channel 3 not zero");

   // Channels 1 and 2 are zero with a single channel
   a_c12_absent: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) && ($past(total) == COUNT_W'(1)) |-> rsp_tdata[23:8] == 16'd0)
      else $error("absent channels 1 and 2 not zero");

endmodule

bind pixel_display_correction_core pdc_checker u_pdc_checker (.*);
